// ===== sv/ecce_pkg.sv =====
package ecce_pkg;

    localparam int NUM_STAGES = 14;

    localparam int TS_W  = 39;
    localparam int OP_W  = 5;
    localparam int VAL_W = 14;

    localparam logic signed [TS_W:0] T_MIN = -40'sd62135596800;
    localparam logic signed [TS_W:0] T_MAX = 40'sd253402300799;

    localparam int DAY_SHIFT = 7;
    localparam int DAY_ODD   = 675;
    localparam int CYC400    = 146097;
    localparam int CYC100    = 36524;
    localparam int CYC4      = 1461;
    localparam int YEAR_DAYS = 365;
    localparam int WEEK_DAYS = 7;
    localparam int MIN_SECS  = 60;
    localparam int HOUR_SECS = 3600;

    localparam logic [31:0] M675   = 32'((64'd1 << 41) / 64'd675);
    localparam logic [4:0]  M400   = 5'((1 << 22) / CYC400);
    localparam logic [19:0] M7     = 20'((1 << 22) / WEEK_DAYS);
    localparam logic [11:0] M60    = 12'((1 << 17) / MIN_SECS);
    localparam logic [5:0]  M3600  = 6'((1 << 17) / HOUR_SECS);
    localparam logic [2:0]  M100   = 3'((1 << 18) / CYC100);
    localparam logic [5:0]  M4     = 6'((1 << 16) / CYC4);
    localparam logic [2:0]  M1     = 3'((1 << 11) / YEAR_DAYS);
    localparam logic [8:0]  M7_SML = 9'(((1 << 11) + WEEK_DAYS - 1) / WEEK_DAYS);

    localparam logic [OP_W-1:0] OP_SEC      = 5'd0;
    localparam logic [OP_W-1:0] OP_MIN      = 5'd1;
    localparam logic [OP_W-1:0] OP_HOUR     = 5'd2;
    localparam logic [OP_W-1:0] OP_DAY      = 5'd3;
    localparam logic [OP_W-1:0] OP_MONTH    = 5'd4;
    localparam logic [OP_W-1:0] OP_YEAR     = 5'd5;
    localparam logic [OP_W-1:0] OP_DOW      = 5'd6;
    localparam logic [OP_W-1:0] OP_ISOWD    = 5'd7;
    localparam logic [OP_W-1:0] OP_YDAY     = 5'd8;
    localparam logic [OP_W-1:0] OP_QTR      = 5'd9;
    localparam logic [OP_W-1:0] OP_WEEK     = 5'd10;
    localparam logic [OP_W-1:0] OP_WKYEAR   = 5'd11;
    localparam logic [OP_W-1:0] OP_DOQ      = 5'd12;
    localparam logic [OP_W-1:0] OP_LAST_SUP = 5'd15;

    localparam logic [2:0] WD_WED = 3'd2;
    localparam logic [2:0] WD_THU = 3'd3;
    localparam logic [2:0] WD_FRI = 3'd4;
    localparam logic [2:0] WD_SAT = 3'd5;

    function automatic logic [8:0] days_before(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
    endfunction

endpackage

// ===== sv/epoch_calendar_component_extractor.sv =====
// Channel   Direction  Handshake              Payload
// command   in         start, busy            i_epoch_seconds, i_op
// result    out        o_strobe (one cycle)   o_component_value, o_ok
//
// Every beat runs from start to o_strobe through a chain of
// reciprocal divides (seconds to days, then 400/100/4/1-year cycles).
// A new command beat is taken in every cycle; busy stays low.
// Reset is synchronous and clears only the stage valid bits.
// The receiver cannot stall, so no beat is ever held back.
module epoch_calendar_component_extractor
    import ecce_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [TS_W-1:0]  i_epoch_seconds,
    input  logic [OP_W-1:0]         i_op,
    output logic                    o_strobe,
    output logic [VAL_W-1:0]        o_component_value,
    output logic                    o_ok
);

    logic [NUM_STAGES:1] r_vld;
    logic [OP_W-1:0]     r_op   [1:13];
    logic                r_inr  [1:13];
    logic [4:0]          r_n400 [5:10];
    logic [1:0]          r_n100 [7:10];
    logic [4:0]          r_n4   [9:10];
    logic [2:0]          r_wd0  [5:13];
    logic [4:0]          r_hour [5:13];
    logic [5:0]          r_sec  [5:13];
    logic [5:0]          r_min  [6:13];

    logic [31:0] r1_x, r2_x;
    logic [6:0]  r1_lo, r2_lo;
    logic [22:0] r2_q0;
    logic [21:0] r3_d, r4_d;
    logic [16:0] r3_sod, r4_sod;
    logic [4:0]  r4_c400, r4_c3600;
    logic [18:0] r4_c7;
    logic [10:0] r4_c60, r5_s60;
    logic [17:0] r5_r400, r6_r400;
    logic [2:0]  r6_c100;
    logic [15:0] r7_r100, r8_r100;
    logic [4:0]  r8_c4;
    logic [10:0] r9_r4, r10_r4;
    logic [1:0]  r10_c1;
    logic [8:0]  r11_doy0, r12_doy0;
    logic        r11_leap, r12_leap, r11_leapp, r12_leapp;
    logic [13:0] r11_year, r12_year, r13_year;
    logic [3:0]  r12_mon, r13_mon;
    logic [2:0]  r12_jan1;
    logic [8:0]  r12_wnum, r13_yday;
    logic [4:0]  r13_day;
    logic [2:0]  r13_qtr;
    logic [6:0]  r13_doq;
    logic [5:0]  r13_week;
    logic        r13_w53c, r13_w53p;
    logic [VAL_W-1:0] r14_val;
    logic        r14_ok;

    logic signed [TS_W:0] n_t, n_u;
    logic        n1_inr;
    logic [63:0] n_p2;
    logic [32:0] n_r3, n_r3c;
    logic [21:0] n3_d;
    logic [16:0] n3_sod;
    logic [26:0] n_p4a;
    logic [41:0] n_p4b;
    logic [28:0] n_p4c;
    logic [22:0] n_p4d;
    logic [21:0] n_r400, n_r7;
    logic [16:0] n_r60, n_r3600;
    logic [4:0]  n5_n400, n5_hour;
    logic [17:0] n5_r400;
    logic [2:0]  n5_wd0;
    logic [10:0] n5_s60;
    logic [5:0]  n5_sec;
    logic [20:0] n_p6;
    logic [5:0]  n6_min;
    logic [17:0] n_r100;
    logic [2:0]  n_q100;
    logic [1:0]  n7_n100;
    logic [15:0] n7_r100;
    logic [21:0] n_p8;
    logic [15:0] n_r4;
    logic [4:0]  n9_n4;
    logic [10:0] n9_r4;
    logic [13:0] n_p10;
    logic [10:0] n_r1;
    logic [2:0]  n_q1;
    logic [1:0]  n_n1;
    logic [8:0]  n11_doy0;
    logic        n11_leap, n11_leapp;
    logic [13:0] n11_year;
    logic [3:0]  n12_mon;
    logic [16:0] n_p12;
    logic [8:0]  n_rd7;
    logic [3:0]  n_j;
    logic [2:0]  n12_jan1;
    logic [8:0]  n12_wnum;
    logic [4:0]  n13_day;
    logic [2:0]  n13_qtr;
    logic [6:0]  n13_doq;
    logic [16:0] n_p13;
    logic [5:0]  n13_week;
    logic        n13_w53c, n13_w53p;
    logic [13:0] n_wyear;
    logic [5:0]  n_wweek;
    logic [VAL_W-1:0] n_sel;
    logic        n14_ok;
    logic [VAL_W-1:0] n14_val;

    assign busy = 1'b0;

    always_comb begin
        n_t    = {i_epoch_seconds[TS_W-1], i_epoch_seconds};
        n1_inr = (n_t >= T_MIN) && (n_t <= T_MAX);
        n_u    = n_t - T_MIN;

        n_p2 = 64'(r1_x) * 64'(M675);

        n_r3   = 33'(r2_x) - 33'(r2_q0) * 33'(DAY_ODD);
        n_r3c  = (n_r3 >= 33'(DAY_ODD)) ? n_r3 - 33'(DAY_ODD) : n_r3;
        n3_d   = (n_r3 >= 33'(DAY_ODD)) ? 22'(r2_q0) + 22'd1 : 22'(r2_q0);
        n3_sod = {n_r3c[9:0], r2_lo};

        n_p4a = 27'(r3_d) * 27'(M400);
        n_p4b = 42'(r3_d) * 42'(M7);
        n_p4c = 29'(r3_sod) * 29'(M60);
        n_p4d = 23'(r3_sod) * 23'(M3600);

        n_r400 = r4_d - 22'(r4_c400) * 22'(CYC400);
        if (n_r400 >= 22'(CYC400)) begin
            n5_n400 = r4_c400 + 5'd1;
            n5_r400 = 18'(n_r400 - 22'(CYC400));
        end else begin
            n5_n400 = r4_c400;
            n5_r400 = n_r400[17:0];
        end
        n_r7   = r4_d - 22'(r4_c7) * 22'(WEEK_DAYS);
        n5_wd0 = (n_r7 >= 22'(WEEK_DAYS)) ? 3'(n_r7 - 22'(WEEK_DAYS)) : n_r7[2:0];
        n_r60  = r4_sod - 17'(r4_c60) * 17'(MIN_SECS);
        if (n_r60 >= 17'(MIN_SECS)) begin
            n5_s60 = r4_c60 + 11'd1;
            n5_sec = 6'(n_r60 - 17'(MIN_SECS));
        end else begin
            n5_s60 = r4_c60;
            n5_sec = n_r60[5:0];
        end
        n_r3600 = r4_sod - 17'(r4_c3600) * 17'(HOUR_SECS);
        n5_hour = (n_r3600 >= 17'(HOUR_SECS)) ? r4_c3600 + 5'd1 : r4_c3600;

        n_p6   = 21'(r5_r400) * 21'(M100);
        n6_min = 6'(r5_s60 - 11'(r_hour[5]) * 11'(MIN_SECS));

        n_r100 = r6_r400 - 18'(r6_c100) * 18'(CYC100);
        if (n_r100 >= 18'(CYC100)) begin
            n_q100 = r6_c100 + 3'd1;
            n_r100 = n_r100 - 18'(CYC100);
        end else begin
            n_q100 = r6_c100;
        end
        if (n_q100 == 3'd4) begin
            n7_n100 = 2'd3;
            n7_r100 = 16'(CYC100);
        end else begin
            n7_n100 = n_q100[1:0];
            n7_r100 = n_r100[15:0];
        end

        n_p8 = 22'(r7_r100) * 22'(M4);

        n_r4 = r8_r100 - 16'(r8_c4) * 16'(CYC4);
        if (n_r4 >= 16'(CYC4)) begin
            n9_n4 = r8_c4 + 5'd1;
            n9_r4 = 11'(n_r4 - 16'(CYC4));
        end else begin
            n9_n4 = r8_c4;
            n9_r4 = n_r4[10:0];
        end

        n_p10 = 14'(r9_r4) * 14'(M1);

        n_r1 = r10_r4 - 11'(r10_c1) * 11'(YEAR_DAYS);
        if (n_r1 >= 11'(YEAR_DAYS)) begin
            n_q1 = 3'(r10_c1) + 3'd1;
            n_r1 = n_r1 - 11'(YEAR_DAYS);
        end else begin
            n_q1 = 3'(r10_c1);
        end
        if (n_q1 == 3'd4) begin
            n_n1     = 2'd3;
            n11_doy0 = 9'(YEAR_DAYS);
        end else begin
            n_n1     = n_q1[1:0];
            n11_doy0 = n_r1[8:0];
        end
        n11_leap  = (n_n1 == 2'd3) && ((r_n4[10] != 5'd24) || (r_n100[10] == 2'd3));
        n11_leapp = (n_n1 == 2'd0) && ((r_n4[10] != 5'd0) || (r_n100[10] == 2'd0));
        n11_year  = 14'(r_n400[10]) * 14'd400 + 14'(r_n100[10]) * 14'd100
                  + 14'(r_n4[10]) * 14'd4 + 14'(n_n1) + 14'd1;

        n12_mon = 4'd1;
        for (int i = 1; i < 12; i++) begin
            n12_mon = n12_mon + 4'((r11_doy0 >= days_before(4'(i), r11_leap)) ? 1 : 0);
        end
        n_p12    = 17'(r11_doy0) * 17'(M7_SML);
        n_rd7    = r11_doy0 - 9'(n_p12[16:11]) * 9'(WEEK_DAYS);
        n_j      = 4'(r_wd0[11]) + 4'(WEEK_DAYS) - 4'(n_rd7);
        n12_jan1 = (n_j >= 4'(WEEK_DAYS)) ? 3'(n_j - 4'(WEEK_DAYS)) : n_j[2:0];
        n12_wnum = r11_doy0 + 9'd10 - 9'(r_wd0[11]);

        n13_day = 5'(r12_doy0 - days_before(r12_mon - 4'd1, r12_leap) + 9'd1);
        case (r12_mon)
            4'd1, 4'd2, 4'd3:    n13_qtr = 3'd1;
            4'd4, 4'd5, 4'd6:    n13_qtr = 3'd2;
            4'd7, 4'd8, 4'd9:    n13_qtr = 3'd3;
            default:             n13_qtr = 3'd4;
        endcase
        n13_doq  = 7'(r12_doy0 + 9'd1
                 - days_before(4'(n13_qtr - 3'd1) * 4'd3, r12_leap));
        n_p13    = 17'(r12_wnum) * 17'(M7_SML);
        n13_week = n_p13[16:11];
        n13_w53c = (r12_jan1 == WD_THU) || (r12_leap && (r12_jan1 == WD_WED));
        n13_w53p = (r12_jan1 == WD_FRI) || (r12_leapp && (r12_jan1 == WD_SAT));

        n_wyear = r13_year;
        n_wweek = r13_week;
        if (r13_week == 6'd0) begin
            n_wyear = r13_year - 14'd1;
            n_wweek = r13_w53p ? 6'd53 : 6'd52;
        end else if ((r13_week == 6'd53) && !r13_w53c) begin
            n_wyear = r13_year + 14'd1;
            n_wweek = 6'd1;
        end
        case (r_op[13])
            OP_SEC:    n_sel = VAL_W'(r_sec[13]);
            OP_MIN:    n_sel = VAL_W'(r_min[13]);
            OP_HOUR:   n_sel = VAL_W'(r_hour[13]);
            OP_DAY:    n_sel = VAL_W'(r13_day);
            OP_MONTH:  n_sel = VAL_W'(r13_mon);
            OP_YEAR:   n_sel = r13_year;
            OP_DOW:    n_sel = VAL_W'((r_wd0[13] == 3'd6) ? 3'd0 : r_wd0[13] + 3'd1);
            OP_ISOWD:  n_sel = VAL_W'(r_wd0[13]) + VAL_W'(1);
            OP_YDAY:   n_sel = VAL_W'(r13_yday);
            OP_QTR:    n_sel = VAL_W'(r13_qtr);
            OP_WEEK:   n_sel = VAL_W'(n_wweek);
            OP_WKYEAR: n_sel = n_wyear;
            OP_DOQ:    n_sel = VAL_W'(r13_doq);
            default:   n_sel = '0;
        endcase
        n14_ok  = r_inr[13] && (r_op[13] <= OP_LAST_SUP);
        n14_val = n14_ok ? n_sel : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NUM_STAGES-1:1], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[1]  <= i_op;
        r_inr[1] <= n1_inr;
        for (int k = 2; k <= 13; k++) begin
            r_op[k]  <= r_op[k-1];
            r_inr[k] <= r_inr[k-1];
        end
        r1_x  <= n_u[TS_W-1:DAY_SHIFT];
        r1_lo <= n_u[DAY_SHIFT-1:0];

        r2_q0 <= n_p2[63:41];
        r2_x  <= r1_x;
        r2_lo <= r1_lo;

        r3_d   <= n3_d;
        r3_sod <= n3_sod;

        r4_c400  <= n_p4a[26:22];
        r4_c7    <= n_p4b[40:22];
        r4_c60   <= n_p4c[27:17];
        r4_c3600 <= n_p4d[21:17];
        r4_d     <= r3_d;
        r4_sod   <= r3_sod;

        r5_r400   <= n5_r400;
        r5_s60    <= n5_s60;
        r_n400[5] <= n5_n400;
        r_wd0[5]  <= n5_wd0;
        r_hour[5] <= n5_hour;
        r_sec[5]  <= n5_sec;
        for (int k = 6; k <= 10; k++) begin
            r_n400[k] <= r_n400[k-1];
        end
        for (int k = 6; k <= 13; k++) begin
            r_wd0[k]  <= r_wd0[k-1];
            r_hour[k] <= r_hour[k-1];
            r_sec[k]  <= r_sec[k-1];
        end

        r6_c100  <= n_p6[20:18];
        r6_r400  <= r5_r400;
        r_min[6] <= n6_min;
        for (int k = 7; k <= 13; k++) begin
            r_min[k] <= r_min[k-1];
        end

        r_n100[7] <= n7_n100;
        r7_r100   <= n7_r100;
        for (int k = 8; k <= 10; k++) begin
            r_n100[k] <= r_n100[k-1];
        end

        r8_c4   <= n_p8[20:16];
        r8_r100 <= r7_r100;

        r_n4[9]  <= n9_n4;
        r9_r4    <= n9_r4;
        r_n4[10] <= r_n4[9];

        r10_c1 <= n_p10[12:11];
        r10_r4 <= r9_r4;

        r11_doy0  <= n11_doy0;
        r11_leap  <= n11_leap;
        r11_leapp <= n11_leapp;
        r11_year  <= n11_year;

        r12_mon   <= n12_mon;
        r12_jan1  <= n12_jan1;
        r12_wnum  <= n12_wnum;
        r12_doy0  <= r11_doy0;
        r12_leap  <= r11_leap;
        r12_leapp <= r11_leapp;
        r12_year  <= r11_year;

        r13_day  <= n13_day;
        r13_mon  <= r12_mon;
        r13_yday <= r12_doy0 + 9'd1;
        r13_qtr  <= n13_qtr;
        r13_doq  <= n13_doq;
        r13_week <= n13_week;
        r13_w53c <= n13_w53c;
        r13_w53p <= n13_w53p;
        r13_year <= r12_year;

        r14_val <= n14_val;
        r14_ok  <= n14_ok;
    end

    assign o_strobe          = r_vld[NUM_STAGES];
    assign o_component_value = r14_val;
    assign o_ok              = r14_ok;

endmodule

// ===== sv/ecce_checker.sv =====
module ecce_checker
    import ecce_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic signed [TS_W-1:0] i_epoch_seconds,
    input logic [OP_W-1:0]        i_op,
    input logic                   o_strobe,
    input logic [VAL_W-1:0]       o_component_value,
    input logic                   o_ok
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy went high");

    a_beat_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##NUM_STAGES o_strobe)
        else $error("result beat missing after command beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_rst_n, NUM_STAGES)) |-> $past(start, NUM_STAGES))
        else $error("result beat without a command beat");

    a_zero_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_ok) |-> (o_component_value == '0))
        else $error("nonzero value with ok low");

    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_op, NUM_STAGES) > OP_LAST_SUP)) |-> !o_ok)
        else $error("unsupported code reported ok");

endmodule

bind epoch_calendar_component_extractor ecce_checker u_ecce_checker (.*);

// ===== bench/epoch_calendar_component_extractor_tb.sv =====
module epoch_calendar_component_extractor_tb;
    import ecce_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             ok;
    } component_t;

    localparam longint SECS_PER_DAY = 86400;
    localparam longint FIRST_SEC    = -64'sd62135596800;
    localparam longint LAST_SEC     = 64'sd253402300799;
    localparam int     CYCLE_LIMIT  = 200000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic signed [TS_W-1:0] i_epoch_seconds = '0;
    logic [OP_W-1:0]        i_op = '0;
    logic                   o_strobe;
    logic [VAL_W-1:0]       o_component_value;
    logic                   o_ok;

    component_t expected_components[$];
    int         error_count = 0;
    int         cycle_count = 0;

    epoch_calendar_component_extractor DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_epoch_seconds   (i_epoch_seconds),
        .i_op              (i_op),
        .o_strobe          (o_strobe),
        .o_component_value (o_component_value),
        .o_ok              (o_ok)
    );

    always #10 i_clk = ~i_clk;

    function automatic bit is_leap(longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint weeks_in_iso_year(longint y);
        longint yp;
        longint pc;
        longint pp;
        yp = (y > 0) ? y - 1 : 0;
        pc = (y + y / 4 - y / 100 + y / 400) % 7;
        pp = (yp + yp / 4 - yp / 100 + yp / 400) % 7;
        return (pc == 4 || pp == 3) ? 53 : 52;
    endfunction

    function automatic longint month_offset(longint m);
        case (m)
            1: return 0;    2: return 31;   3: return 59;   4: return 90;
            5: return 120;  6: return 151;  7: return 181;  8: return 212;
            9: return 243;  10: return 273; 11: return 304; default: return 334;
        endcase
    endfunction

    function automatic component_t extract_component(logic signed [TS_W-1:0] ts,
                                                     logic [OP_W-1:0] op);
        component_t r;
        longint t, days, sod, z, era, doe, yoe, doy, mp;
        longint y, m, d, wday, isowd, yday, q, week, wyear, doq, v;
        bit     leap;
        r = '0;
        t = ts;
        if (op > OP_LAST_SUP || t < FIRST_SEC || t > LAST_SEC) begin
            return r;
        end
        days = t / SECS_PER_DAY;
        sod = t % SECS_PER_DAY;
        if (sod < 0) begin
            sod += SECS_PER_DAY;
            days -= 1;
        end
        z = days + 719468;
        era = (z >= 0 ? z : z - 146096) / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        d = doy - (153 * mp + 2) / 5 + 1;
        m = (mp < 10) ? mp + 3 : mp - 9;
        y = yoe + era * 400 + ((m <= 2) ? 1 : 0);
        wday = ((days % 7) + 11) % 7;
        isowd = (wday == 0) ? 7 : wday;
        leap = is_leap(y);
        yday = month_offset(m) + d + ((leap && m > 2) ? 1 : 0);
        q = (m - 1) / 3 + 1;
        doq = yday - (month_offset((q - 1) * 3 + 1) + ((leap && q > 1) ? 1 : 0));
        week = (yday - isowd + 10) / 7;
        wyear = y;
        if (week < 1) begin
            wyear = y - 1;
            week = weeks_in_iso_year(wyear);
        end else if (week > weeks_in_iso_year(y)) begin
            wyear = y + 1;
            week = 1;
        end
        case (op)
            OP_SEC:    v = sod % 60;
            OP_MIN:    v = (sod / 60) % 60;
            OP_HOUR:   v = sod / 3600;
            OP_DAY:    v = d;
            OP_MONTH:  v = m;
            OP_YEAR:   v = y;
            OP_DOW:    v = wday;
            OP_ISOWD:  v = isowd;
            OP_YDAY:   v = yday;
            OP_QTR:    v = q;
            OP_WEEK:   v = week;
            OP_WKYEAR: v = wyear;
            OP_DOQ:    v = doq;
            default:   v = 0;
        endcase
        r.value = VAL_W'(v);
        r.ok = 1'b1;
        return r;
    endfunction

    // Idles before the beat at random unless the caller asks for back-to-back beats.
    task automatic send_timestamp(longint ts, logic [OP_W-1:0] op, bit allow_idle);
        while (allow_idle && $urandom_range(99) < 36) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_epoch_seconds <= TS_W'(ts);
        i_op <= op;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        expected_components.push_back(extract_component(TS_W'(ts), op));
        @(negedge i_clk);
    endtask

    function automatic longint random_span(longint lo, longint hi);
        longint r;
        r = {$urandom(), $urandom()};
        if (r < 0) begin
            r = -r;
        end
        return lo + r % (hi - lo + 1);
    endfunction

    task automatic test_field_extremes();
        send_timestamp(FIRST_SEC, OP_YEAR, 1);
        send_timestamp(FIRST_SEC - 1, OP_YEAR, 1);
        send_timestamp(LAST_SEC, OP_WKYEAR, 1);
        send_timestamp(LAST_SEC + 1, OP_SEC, 1);
        send_timestamp(-(64'sd1 << 38), OP_DAY, 1);
        send_timestamp((64'sd1 << 38) - 1, OP_MIN, 1);
        send_timestamp(0, OP_DOW, 1);
        send_timestamp(-1, OP_SEC, 1);
        send_timestamp(0, 5'd31, 1);
        send_timestamp(0, 5'd16, 1);
    endtask

    task automatic test_every_code();
        for (int op = 0; op <= 15; op++) begin
            send_timestamp(64'sd951825599, OP_W'(op), 1);
        end
    endtask

    task automatic test_leap_and_year_edges();
        send_timestamp(64'sd951782400, OP_DOQ, 1);
        send_timestamp(64'sd1230768000, OP_WEEK, 1);
        send_timestamp(64'sd1104451200, OP_WKYEAR, 1);
    endtask

    task automatic test_random_mix(int count, bit allow_idle);
        longint ts;
        logic [OP_W-1:0] op;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0: ts = random_span(-(64'sd1 << 38), (64'sd1 << 38) - 1);
                1: ts = (($urandom_range(1)) ? LAST_SEC : FIRST_SEC)
                        + $signed($urandom_range(4)) - 2;
                2: ts = random_span(-2000, 2000) * SECS_PER_DAY
                        + random_span(-2, 2) + 64'sd946684800 * $urandom_range(1);
                default: ts = random_span(FIRST_SEC, LAST_SEC);
            endcase
            op = ($urandom_range(9) == 0) ? OP_W'($urandom_range(31)) : OP_W'($urandom_range(15));
            send_timestamp(ts, op, allow_idle);
        end
    endtask

    always @(posedge i_clk) begin
        component_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n && o_strobe) begin
            if (expected_components.size() == 0) begin
                $error("unexpected beat: value %0d ok %0d", o_component_value, o_ok);
                error_count++;
            end else begin
                want = expected_components.pop_front();
                if (o_component_value !== want.value) begin
                    $error("component_value expected %0d actual %0d", want.value,
                           o_component_value);
                    error_count++;
                end
                if (o_ok !== want.ok) begin
                    $error("ok expected %0d actual %0d", want.ok, o_ok);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_field_extremes();
        test_every_code();
        test_leap_and_year_edges();
        test_random_mix(1200, 1);
        test_random_mix(300, 0);
        test_random_mix(420, 1);
        start <= 1'b0;
        while (expected_components.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_STAGES + 10) @(posedge i_clk);
        if (error_count == 0 && expected_components.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/ecce_pkg.sv
sv/epoch_calendar_component_extractor.sv
sv/ecce_checker.sv
bench/epoch_calendar_component_extractor_tb.sv
